### src/brcc_pkg.sv
// Shared constants, register map and types for the balance robot cascade controller.
package brcc_pkg;

    // Speed loop runs once every SPEED_PERIOD+1 ticks
    localparam int SPEED_PERIOD = 4;
    localparam int SPEED_DIV    = SPEED_PERIOD + 1;

    // floor(2^31 / SPEED_DIV): estimate is at most one short of the true quotient
    localparam logic [31:0] SPEED_RECIP = 32'((64'd1 << 31) / SPEED_DIV);

    localparam logic [14:0] DUTY_MAX  = 15'd32440;   // 0.99 in Q1.15
    localparam logic [14:0] FILT_COEF = 15'd19661;   // 0.3 in Q0.16

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LOST_ANGLE_LIMIT = 3'd0,
        REG_TILT_GAIN_P      = 3'd1,
        REG_TILT_GAIN_D      = 3'd2,
        REG_SPEED_GAIN_P     = 3'd3,
        REG_SPEED_GAIN_I     = 3'd4,
        REG_POSITION_LIMIT   = 3'd5,
        REG_LEFT_DEADBAND    = 3'd6,
        REG_RIGHT_DEADBAND   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] lost_angle_limit;
        logic [23:0] tilt_gain_p;
        logic [23:0] tilt_gain_d;
        logic [23:0] speed_gain_p;
        logic [23:0] speed_gain_i;
        logic [22:0] position_limit;
        logic [14:0] left_deadband;
        logic [14:0] right_deadband;
    } t_cfg;

    localparam logic [14:0] RST_LOST_ANGLE_LIMIT = 15'd2860;
    localparam logic [22:0] RST_POSITION_LIMIT   = 23'd8388607;

endpackage

### src/balance_robot_cascade_controller_core.sv
// Top level: PD tilt loop and PI speed loop sequenced over one shared multiplier.
//
// One control tick enters on the input channel (i_valid / o_stall) and produces
// exactly one result on the output channel (o_valid / i_stall). A transfer
// happens on a rising edge with valid high and stall low.
// Work runs through a sequencer around a single 33x33 signed multiplier and one
// shared accumulate adder. A tick that runs the speed loop (one in every
// SPEED_PERIOD+1) steps through PD1-PD3, FS, POS, SP, SI, SO, ABS, DQ, DR, DC and
// OUT; the other ticks step through PD1-PD3, RAMP and OUT. Each item then returns
// to S_IDLE, where the next tick is accepted; the multiplier chain of the speed
// loop and the divide-by-constant of the ramp make the speed ticks the longer ones.
// o_stall is high while an item is in work. A finished result sits in the
// output register; the next item is accepted meanwhile and only waits at its
// last step if the receiver still stalls the previous result.
// Reset (synchronous, active low) loads the register defaults, clears the
// filter, position integral, speed loop output and loop phase, and drops
// o_valid. Registers are written through the APB-style port; pready is tied high.
module balance_robot_cascade_controller_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brcc_pkg::ADDR_W-1:0] paddr,
    input  logic [brcc_pkg::DATA_W-1:0] pwdata,
    output logic [brcc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [15:0]          i_tilt_angle,
    input  logic signed [15:0]          i_tilt_rate,
    input  logic signed [15:0]          i_left_wheel_speed,
    input  logic signed [15:0]          i_right_wheel_speed,
    input  logic signed [15:0]          i_speed_setpoint,
    input  logic signed [15:0]          i_turn_cmd,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [14:0]                 o_left_duty,
    output logic                        o_left_reverse,
    output logic [14:0]                 o_right_duty,
    output logic                        o_right_reverse,
    output logic                        o_stopped
);

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_PD1  = 15'h0002,
        S_PD2  = 15'h0004,
        S_PD3  = 15'h0008,
        S_FS   = 15'h0010,
        S_POS  = 15'h0020,
        S_SP   = 15'h0040,
        S_SI   = 15'h0080,
        S_SO   = 15'h0100,
        S_ABS  = 15'h0200,
        S_DQ   = 15'h0400,
        S_DR   = 15'h0800,
        S_DC   = 15'h1000,
        S_RAMP = 15'h2000,
        S_OUT  = 15'h4000
    } t_state;

    brcc_pkg::t_cfg cfg;

    brcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    assign pready = 1'b1;

    // control and loop state
    t_state              r_state;
    logic [7:0]          r_phase;
    logic signed [31:0]  r_fs;
    logic signed [31:0]  r_ps;
    logic signed [31:0]  r_slo;

    // item in work
    logic signed [15:0]  r_angle;
    logic signed [15:0]  r_rate;
    logic signed [15:0]  r_tspeed;
    logic signed [15:0]  r_turn;
    logic signed [32:0]  r_diff;
    logic signed [65:0]  r_prod;
    logic signed [56:0]  r_acc;
    logic signed [28:0]  r_pd;

    // ramp: |speed_loop_out| = r_q0*DIV + r_r0, r_ramp = floor(|slo|*(phase+1)/DIV)
    logic [31:0]         r_mag;
    logic [31:0]         r_q;
    logic [31:0]         r_q0;
    logic [7:0]          r_r0;
    logic [31:0]         r_ramp;
    logic [7:0]          r_rem;
    logic                r_neg;

    // output register
    logic                r_out_valid;
    logic [14:0]         r_left_duty;
    logic                r_left_reverse;
    logic [14:0]         r_right_duty;
    logic                r_right_reverse;
    logic                r_stopped;

    // shared multiplier
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PD1: begin
                mul_a = $signed({9'd0, cfg.tilt_gain_p});
                mul_b = 33'(r_angle);
            end
            S_PD2: begin
                mul_a = $signed({9'd0, cfg.tilt_gain_d});
                mul_b = 33'(r_rate);
            end
            S_PD3: begin
                mul_a = $signed({18'd0, brcc_pkg::FILT_COEF});
                mul_b = r_diff;
            end
            S_SP: begin
                mul_a = $signed({9'd0, cfg.speed_gain_p});
                mul_b = 33'(r_fs);
            end
            S_SI: begin
                mul_a = $signed({9'd0, cfg.speed_gain_i});
                mul_b = 33'(r_ps);
            end
            S_DQ: begin
                mul_a = $signed({1'b0, brcc_pkg::SPEED_RECIP});
                mul_b = $signed({1'b0, r_mag});
            end
            S_DR: begin
                // quotient estimate straight from the product, r_q loads at this edge
                mul_a = $signed({1'b0, r_prod[62:31]});
                mul_b = $signed(33'(brcc_pkg::SPEED_DIV));
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // input side: mean wheel speed in Q.8 minus filter state
    logic signed [16:0]  wheel_sum;
    logic signed [23:0]  mean_speed;
    logic signed [32:0]  diff_in;

    assign wheel_sum  = 17'(i_left_wheel_speed) + 17'(i_right_wheel_speed);
    assign mean_speed = {wheel_sum, 7'd0};
    assign diff_in    = 33'(mean_speed) - 33'(r_fs);

    // accumulate: PD sum and speed loop sum both finish here
    logic signed [57:0]  acc_sum;
    logic signed [48:0]  so_shift;
    logic signed [31:0]  so_sat;

    assign acc_sum  = 58'(r_acc) + 58'($signed(r_prod[56:0]));
    assign so_shift = acc_sum[57:9];

    always_comb begin
        if ((so_shift[48:31] == '0) || (so_shift[48:31] == '1)) begin
            so_sat = so_shift[31:0];
        end else if (so_shift[48]) begin
            so_sat = 32'sh8000_0000;
        end else begin
            so_sat = 32'sh7FFF_FFFF;
        end
    end

    // low-pass filter update
    logic signed [33:0]  fs_sum;
    assign fs_sum = 34'(r_fs) + 34'($signed(r_prod[49:16]));

    // position integral with clamp
    logic signed [23:0]  tspeed_q8;
    logic signed [33:0]  pos_sum;
    logic signed [33:0]  pos_lim;
    logic signed [31:0]  pos_clamped;

    assign tspeed_q8 = {r_tspeed, 8'd0};
    assign pos_sum   = 34'(r_ps) + 34'(r_fs) + 34'(tspeed_q8);
    assign pos_lim   = $signed({3'd0, cfg.position_limit, 8'd0});

    always_comb begin
        if (pos_sum > pos_lim) begin
            pos_clamped = 32'(pos_lim);
        end else if (pos_sum < -pos_lim) begin
            pos_clamped = 32'(-pos_lim);
        end else begin
            pos_clamped = pos_sum[31:0];
        end
    end

    // quotient correction for the divide by SPEED_DIV
    logic [32:0]         rem_full;
    logic [9:0]          rem_lo;
    logic                rem_ge;
    logic [31:0]         q0_next;
    logic [7:0]          r0_next;

    assign rem_full = {1'b0, r_mag} - r_prod[32:0];
    assign rem_lo   = rem_full[9:0];
    assign rem_ge   = rem_lo >= 10'(brcc_pkg::SPEED_DIV);
    assign q0_next  = rem_ge ? r_q + 32'd1 : r_q;
    assign r0_next  = rem_ge ? 8'(rem_lo - 10'(brcc_pkg::SPEED_DIV)) : rem_lo[7:0];

    // ramp step for ticks between speed loop runs
    logic [8:0]          ramp_rsum;
    logic                ramp_carry;

    assign ramp_rsum  = {1'b0, r_rem} + {1'b0, r_r0};
    assign ramp_carry = ramp_rsum >= 9'(brcc_pkg::SPEED_DIV);

    // drive and per-side output
    logic signed [33:0]  ramp_s;
    logic signed [33:0]  drive;
    logic signed [34:0]  lval;
    logic signed [34:0]  rval;
    logic [15:0]         left_out;
    logic [15:0]         right_out;
    logic [15:0]         angle_mag;
    logic                stop;

    function automatic logic [15:0] side_out(input logic signed [34:0] v,
                                             input logic [14:0] band);
        logic [34:0] mag;
        logic [35:0] tot;
        logic [14:0] duty;
        mag  = v[34] ? 35'(-v) : 35'(v);
        tot  = {1'b0, mag} + 36'(band);
        duty = (tot > 36'(brcc_pkg::DUTY_MAX)) ? brcc_pkg::DUTY_MAX : tot[14:0];
        return {v[34], duty};
    endfunction

    assign ramp_s    = r_neg ? -$signed({2'd0, r_ramp}) : $signed({2'd0, r_ramp});
    assign drive     = 34'(r_pd) + ramp_s;
    assign lval      = 35'(drive) - 35'(r_turn);
    assign rval      = 35'(drive) + 35'(r_turn);
    assign left_out  = side_out(lval, cfg.left_deadband);
    assign right_out = side_out(rval, cfg.right_deadband);
    assign angle_mag = r_angle[15] ? 16'(-r_angle) : 16'(r_angle);
    assign stop      = angle_mag >= {1'b0, cfg.lost_angle_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_fs        <= '0;
            r_ps        <= '0;
            r_slo       <= '0;
            r_q0        <= '0;
            r_r0        <= '0;
            r_ramp      <= '0;
            r_rem       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_angle  <= i_tilt_angle;
                        r_rate   <= i_tilt_rate;
                        r_tspeed <= i_speed_setpoint;
                        r_turn   <= i_turn_cmd;
                        r_diff   <= diff_in;
                        r_state  <= S_PD1;
                    end
                end
                S_PD1: begin
                    r_prod  <= mul_p;
                    r_state <= S_PD2;
                end
                S_PD2: begin
                    r_acc   <= $signed(r_prod[56:0]);
                    r_prod  <= mul_p;
                    r_state <= S_PD3;
                end
                S_PD3: begin
                    r_pd    <= acc_sum[41:13];
                    r_prod  <= mul_p;
                    r_state <= (r_phase == '0) ? S_FS : S_RAMP;
                end
                S_FS: begin
                    r_fs    <= fs_sum[31:0];
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_ps    <= pos_clamped;
                    r_state <= S_SP;
                end
                S_SP: begin
                    r_prod  <= mul_p;
                    r_state <= S_SI;
                end
                S_SI: begin
                    r_acc   <= $signed(r_prod[56:0]);
                    r_prod  <= mul_p;
                    r_state <= S_SO;
                end
                S_SO: begin
                    r_slo   <= so_sat;
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_mag   <= r_slo[31] ? 32'(-r_slo) : 32'(r_slo);
                    r_neg   <= r_slo[31];
                    r_state <= S_DQ;
                end
                S_DQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_DR;
                end
                S_DR: begin
                    r_q     <= r_prod[62:31];
                    r_prod  <= mul_p;
                    r_state <= S_DC;
                end
                S_DC: begin
                    // first tick of the period: ramp factor is 1/DIV
                    r_q0    <= q0_next;
                    r_r0    <= r0_next;
                    r_ramp  <= q0_next;
                    r_rem   <= r0_next;
                    r_state <= S_OUT;
                end
                S_RAMP: begin
                    r_ramp  <= r_ramp + r_q0 + 32'(ramp_carry);
                    r_rem   <= ramp_carry ? 8'(ramp_rsum - 9'(brcc_pkg::SPEED_DIV))
                                          : ramp_rsum[7:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid     <= 1'b1;
                        r_stopped       <= stop;
                        r_left_duty     <= stop ? '0 : left_out[14:0];
                        r_left_reverse  <= stop ? 1'b0 : left_out[15];
                        r_right_duty    <= stop ? '0 : right_out[14:0];
                        r_right_reverse <= stop ? 1'b0 : right_out[15];
                        r_phase <= (r_phase == 8'(brcc_pkg::SPEED_PERIOD)) ? '0
                                                                           : r_phase + 8'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_left_duty     = r_left_duty;
    assign o_left_reverse  = r_left_reverse;
    assign o_right_duty    = r_right_duty;
    assign o_right_reverse = r_right_reverse;
    assign o_stopped       = r_stopped;

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stopped) |-> (o_left_duty == '0 && o_right_duty == '0 &&
                                    !o_left_reverse && !o_right_reverse))
        else $error("stopped result carries drive");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_duty <= brcc_pkg::DUTY_MAX && o_right_duty <= brcc_pkg::DUTY_MAX))
        else $error("duty above saturation limit");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 8'(brcc_pkg::SPEED_PERIOD))
        else $error("loop phase out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (9'(r_rem) < 9'(brcc_pkg::SPEED_DIV)) && (9'(r_r0) < 9'(brcc_pkg::SPEED_DIV)))
        else $error("ramp remainder not below divisor");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_PD1))
        else $error("accepted transfer did not start the sequence");

endmodule

### src/brcc_regs.sv
// Configuration register file behind the APB-style port.
module brcc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brcc_pkg::ADDR_W-1:0] paddr,
    input  logic [brcc_pkg::DATA_W-1:0] pwdata,
    output logic [brcc_pkg::DATA_W-1:0] prdata,
    output brcc_pkg::t_cfg             o_cfg
);

    brcc_pkg::t_cfg   r_cfg;
    brcc_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = brcc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lost_angle_limit <= brcc_pkg::RST_LOST_ANGLE_LIMIT;
            r_cfg.tilt_gain_p      <= '0;
            r_cfg.tilt_gain_d      <= '0;
            r_cfg.speed_gain_p     <= '0;
            r_cfg.speed_gain_i     <= '0;
            r_cfg.position_limit   <= brcc_pkg::RST_POSITION_LIMIT;
            r_cfg.left_deadband    <= '0;
            r_cfg.right_deadband   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                brcc_pkg::REG_LOST_ANGLE_LIMIT: r_cfg.lost_angle_limit <= pwdata[14:0];
                brcc_pkg::REG_TILT_GAIN_P:      r_cfg.tilt_gain_p      <= pwdata[23:0];
                brcc_pkg::REG_TILT_GAIN_D:      r_cfg.tilt_gain_d      <= pwdata[23:0];
                brcc_pkg::REG_SPEED_GAIN_P:     r_cfg.speed_gain_p     <= pwdata[23:0];
                brcc_pkg::REG_SPEED_GAIN_I:     r_cfg.speed_gain_i     <= pwdata[23:0];
                brcc_pkg::REG_POSITION_LIMIT:   r_cfg.position_limit   <= pwdata[22:0];
                brcc_pkg::REG_LEFT_DEADBAND:    r_cfg.left_deadband    <= pwdata[14:0];
                brcc_pkg::REG_RIGHT_DEADBAND:   r_cfg.right_deadband   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            brcc_pkg::REG_LOST_ANGLE_LIMIT: prdata = 32'(r_cfg.lost_angle_limit);
            brcc_pkg::REG_TILT_GAIN_P:      prdata = 32'(r_cfg.tilt_gain_p);
            brcc_pkg::REG_TILT_GAIN_D:      prdata = 32'(r_cfg.tilt_gain_d);
            brcc_pkg::REG_SPEED_GAIN_P:     prdata = 32'(r_cfg.speed_gain_p);
            brcc_pkg::REG_SPEED_GAIN_I:     prdata = 32'(r_cfg.speed_gain_i);
            brcc_pkg::REG_POSITION_LIMIT:   prdata = 32'(r_cfg.position_limit);
            brcc_pkg::REG_LEFT_DEADBAND:    prdata = 32'(r_cfg.left_deadband);
            brcc_pkg::REG_RIGHT_DEADBAND:   prdata = 32'(r_cfg.right_deadband);
            default:                        prdata = '0;
        endcase
    end

endmodule

### tb/tb_balance_robot_cascade_controller_core.sv
// Self-checking testbench for the balance robot cascade controller core.
`timescale 1ns / 100ps

module tb_balance_robot_cascade_controller_core;
    import brcc_pkg::*;

    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     RAND_PHASES   = 12;
    localparam int     PHASE_ITEMS   = 104;
    localparam int     DIR_N         = 25;
    localparam int     MAX_REPORTS   = 10;
    localparam longint FILT_K        = longint'(FILT_COEF);
    localparam longint DUTY_CAP      = longint'(DUTY_MAX);
    localparam longint SO_MAX        = 64'sd2147483647;
    localparam longint SO_MIN        = -64'sd2147483648;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] tilt_rate;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic signed [15:0] speed_setpoint;
        logic signed [15:0] turn_cmd;
    } tick_t;

    typedef struct packed {
        logic [14:0] left_duty;
        logic        left_rev;
        logic [14:0] right_duty;
        logic        right_rev;
        logic        stopped;
    } duty_res_t;

    typedef struct packed {
        logic [1:0] cfg_set;
        tick_t      tick;
        logic       known;
        duty_res_t  res;
    } dir_row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid;
    logic                o_stall;
    logic signed [15:0]  i_tilt_angle;
    logic signed [15:0]  i_tilt_rate;
    logic signed [15:0]  i_left_wheel_speed;
    logic signed [15:0]  i_right_wheel_speed;
    logic signed [15:0]  i_speed_setpoint;
    logic signed [15:0]  i_turn_cmd;
    logic                o_valid;
    logic                i_stall;
    logic [14:0]         o_left_duty;
    logic                o_left_reverse;
    logic [14:0]         o_right_duty;
    logic                o_right_reverse;
    logic                o_stopped;

    balance_robot_cascade_controller_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_tilt_angle        (i_tilt_angle),
        .i_tilt_rate         (i_tilt_rate),
        .i_left_wheel_speed  (i_left_wheel_speed),
        .i_right_wheel_speed (i_right_wheel_speed),
        .i_speed_setpoint    (i_speed_setpoint),
        .i_turn_cmd          (i_turn_cmd),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_left_duty         (o_left_duty),
        .o_left_reverse      (o_left_reverse),
        .o_right_duty        (o_right_duty),
        .o_right_reverse     (o_right_reverse),
        .o_stopped           (o_stopped)
    );

    // controller shadow: configuration and loop state
    t_cfg      cfg;
    int        filt_speed;
    int        pos_sum;
    int        spd_out;
    int        loop_phase;

    duty_res_t duty_q[$];
    int        err_cnt;
    int        cycle_cnt;
    int        gap_pct;
    int        stall_pct;
    int        stall_run;
    logic      quiet;

    dir_row_t  dir_rows[DIR_N];
    t_cfg      dir_cfgs[4];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    function automatic logic [15:0] side_out(input longint v, input longint band);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = mag + band;
        if (mag > DUTY_CAP) begin
            mag = DUTY_CAP;
        end
        return {(v < 0), mag[14:0]};
    endfunction

    function automatic duty_res_t predict_tick(input tick_t t);
        longint    ang, rate, pd, fs, mean, pos, lim, so, drive;
        logic [15:0] ls, rs;
        duty_res_t r;
        ang  = longint'(t.tilt_angle);
        rate = longint'(t.tilt_rate);
        pd = (longint'(cfg.tilt_gain_p) * ang + longint'(cfg.tilt_gain_d) * rate) >>> 13;
        if (loop_phase == 0) begin
            mean = (longint'(t.left_speed) + longint'(t.right_speed)) * 128;
            fs   = longint'(filt_speed);
            fs   = fs + ((FILT_K * (mean - fs)) >>> 16);
            pos  = longint'(pos_sum) + fs + longint'(t.speed_setpoint) * 256;
            lim  = longint'(cfg.position_limit) * 256;
            if (pos > lim) begin
                pos = lim;
            end else if (pos < -lim) begin
                pos = -lim;
            end
            so = (longint'(cfg.speed_gain_p) * fs + longint'(cfg.speed_gain_i) * pos) >>> 9;
            if (so > SO_MAX) begin
                so = SO_MAX;
            end else if (so < SO_MIN) begin
                so = SO_MIN;
            end
            filt_speed = int'(fs);
            pos_sum    = int'(pos);
            spd_out    = int'(so);
        end
        // ramp of the speed term, truncating division
        drive = pd + (longint'(spd_out) * longint'(loop_phase + 1)) / longint'(SPEED_DIV);
        loop_phase = (loop_phase >= SPEED_PERIOD) ? 0 : loop_phase + 1;
        if (((ang < 0) ? -ang : ang) >= longint'(cfg.lost_angle_limit)) begin
            r = '0;
            r.stopped = 1'b1;
        end else begin
            ls = side_out(drive - longint'(t.turn_cmd), longint'(cfg.left_deadband));
            rs = side_out(drive + longint'(t.turn_cmd), longint'(cfg.right_deadband));
            r.left_duty  = ls[14:0];
            r.left_rev   = ls[15];
            r.right_duty = rs[14:0];
            r.right_rev  = rs[15];
            r.stopped    = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rnd_s16(input int m);
        int v;
        if (m >= 32768) begin
            return 16'($urandom);
        end
        v = int'($urandom_range(0, 2 * m)) - m;
        return v[15:0];
    endfunction

    task automatic send_tick(input tick_t t, input logic known, input duty_res_t typed);
        duty_res_t pred;
        @(negedge i_clk);
        i_valid             <= 1'b1;
        i_tilt_angle        <= t.tilt_angle;
        i_tilt_rate         <= t.tilt_rate;
        i_left_wheel_speed  <= t.left_speed;
        i_right_wheel_speed <= t.right_speed;
        i_speed_setpoint    <= t.speed_setpoint;
        i_turn_cmd          <= t.turn_cmd;
        do @(posedge i_clk); while (o_stall);
        // transfer taken at this edge
        pred = predict_tick(t);
        duty_q.push_back(known ? typed : pred);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val, input logic garble);
        logic [31:0] mask, wdata, kept;
        case (idx)
            REG_LOST_ANGLE_LIMIT, REG_LEFT_DEADBAND, REG_RIGHT_DEADBAND: mask = 32'h7FFF;
            REG_POSITION_LIMIT: mask = 32'h7F_FFFF;
            default: mask = 32'hFF_FFFF;
        endcase
        wdata = garble ? ((val & mask) | ($urandom & ~mask)) : val;
        kept  = wdata & mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOST_ANGLE_LIMIT: cfg.lost_angle_limit = kept[14:0];
            REG_TILT_GAIN_P:      cfg.tilt_gain_p      = kept[23:0];
            REG_TILT_GAIN_D:      cfg.tilt_gain_d      = kept[23:0];
            REG_SPEED_GAIN_P:     cfg.speed_gain_p     = kept[23:0];
            REG_SPEED_GAIN_I:     cfg.speed_gain_i     = kept[23:0];
            REG_POSITION_LIMIT:   cfg.position_limit   = kept[22:0];
            REG_LEFT_DEADBAND:    cfg.left_deadband    = kept[14:0];
            REG_RIGHT_DEADBAND:   cfg.right_deadband   = kept[14:0];
            default: ;
        endcase
        // read back the same register
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== kept) begin
            flag_error($sformatf("reg %0d readback: expected %h got %h", idx, kept, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_cfg(input t_cfg c, input logic garble);
        reg_write(REG_LOST_ANGLE_LIMIT, 32'(c.lost_angle_limit), garble);
        reg_write(REG_TILT_GAIN_P,      32'(c.tilt_gain_p),      garble);
        reg_write(REG_TILT_GAIN_D,      32'(c.tilt_gain_d),      garble);
        reg_write(REG_SPEED_GAIN_P,     32'(c.speed_gain_p),     garble);
        reg_write(REG_SPEED_GAIN_I,     32'(c.speed_gain_i),     garble);
        reg_write(REG_POSITION_LIMIT,   32'(c.position_limit),   garble);
        reg_write(REG_LEFT_DEADBAND,    32'(c.left_deadband),    garble);
        reg_write(REG_RIGHT_DEADBAND,   32'(c.right_deadband),   garble);
    endtask

    // receiver backpressure in bursts
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            stall_run = 0;
        end else if (stall_run != 0) begin
            stall_run--;
        end else if (int'($urandom_range(0, 99)) < stall_pct) begin
            stall_run = $urandom_range(1, 9);
        end
        i_stall <= (stall_run != 0);
    end

    always @(posedge i_clk) begin : result_check
        duty_res_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_left_duty, o_left_reverse, o_right_duty, o_right_reverse, o_stopped};
            if (duty_q.size() == 0) begin
                flag_error($sformatf("result with nothing pending: %p", got));
            end else begin
                want = duty_q.pop_front();
                if (got !== want) begin
                    flag_error($sformatf(
                        "mismatch: exp L %0d/%0d R %0d/%0d S %0d, got L %0d/%0d R %0d/%0d S %0d",
                        want.left_duty, want.left_rev, want.right_duty, want.right_rev,
                        want.stopped, got.left_duty, got.left_rev, got.right_duty,
                        got.right_rev, got.stopped));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_balance_robot_cascade_controller_core: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        tick_t t;
        t_cfg  rc;
        int    kind;
        logic  tame;
        logic  garble;

        err_cnt             = 0;
        cycle_cnt           = 0;
        stall_run           = 0;
        quiet               = 1'b0;
        gap_pct             = 15;
        stall_pct           = 15;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        i_valid             = 1'b0;
        i_stall             = 1'b0;
        i_tilt_angle        = '0;
        i_tilt_rate         = '0;
        i_left_wheel_speed  = '0;
        i_right_wheel_speed = '0;
        i_speed_setpoint    = '0;
        i_turn_cmd          = '0;

        cfg                  = '0;
        cfg.lost_angle_limit = RST_LOST_ANGLE_LIMIT;
        cfg.position_limit   = RST_POSITION_LIMIT;
        filt_speed           = 0;
        pos_sum              = 0;
        spd_out              = 0;
        loop_phase           = 0;

        // set 1: zero tilt limit, everything else at maximum
        dir_cfgs[0] = '0;
        dir_cfgs[1] = '{15'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                        23'h7FFFFF, 15'h7FFF, 15'h7FFF};
        // set 2: widest tilt limit, max gains, position clamp at zero
        dir_cfgs[2] = '{15'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                        23'd0, 15'h7FFF, 15'h7FFF};
        // set 3: plausible tuning
        dir_cfgs[3] = '{15'd2860, 24'h010000, 24'h002000, 24'd300, 24'd20,
                        23'd1000, 15'd1000, 15'd2000};

        dir_rows = '{
            '{2'd0, '{0, 0, 0, 0, 0, 0},                       1'b1, '{0, 0, 0, 0, 0}},
            '{2'd0, '{0, 0, 0, 0, 0, 32767},                   1'b1, '{32440, 1, 32440, 0, 0}},
            '{2'd0, '{0, 0, 0, 0, 0, -32768},                  1'b1, '{32440, 0, 32440, 1, 0}},
            '{2'd0, '{0, 0, 0, 0, 0, 100},                     1'b1, '{100, 1, 100, 0, 0}},
            '{2'd0, '{2859, 0, 0, 0, 0, 0},                    1'b1, '{0, 0, 0, 0, 0}},
            '{2'd0, '{2860, 0, 0, 0, 0, 0},                    1'b1, '{0, 0, 0, 0, 1}},
            '{2'd0, '{-2860, 0, 0, 0, 0, 700},                 1'b1, '{0, 0, 0, 0, 1}},
            '{2'd0, '{-2859, -32768, 32767, 32767, 32767, -5}, 1'b1, '{5, 0, 5, 1, 0}},
            '{2'd0, '{32767, 32767, -32768, -32768, -32768, 0}, 1'b1, '{0, 0, 0, 0, 1}},
            '{2'd0, '{-32768, 0, 0, 0, 0, 0},                  1'b1, '{0, 0, 0, 0, 1}},
            '{2'd1, '{0, 0, 0, 0, 0, 0},                       1'b1, '{0, 0, 0, 0, 1}},
            '{2'd1, '{32767, 32767, 0, 0, 0, 32767},           1'b1, '{0, 0, 0, 0, 1}},
            '{2'd1, '{1, -1, 32767, -32768, 32767, -32768},    1'b1, '{0, 0, 0, 0, 1}},
            '{2'd2, '{1, 0, 0, 0, 0, 0},                       1'b0, '0},
            '{2'd2, '{-1, -1, 0, 0, 0, 0},                     1'b0, '0},
            '{2'd2, '{0, 32767, 32767, 32767, 0, -32768},      1'b0, '0},
            '{2'd2, '{32766, -32768, -32768, -32768, 0, 0},    1'b0, '0},
            '{2'd2, '{-32768, 0, 0, 0, 32767, 32767},          1'b0, '0},
            '{2'd3, '{100, -200, 50, 60, 10, 0},               1'b0, '0},
            '{2'd3, '{-150, 300, -40, -45, -20, 1500},         1'b0, '0},
            '{2'd3, '{2859, 0, 120, 100, 0, -800},             1'b0, '0},
            '{2'd3, '{-2860, 0, 120, 100, 30, 0},              1'b0, '0},
            '{2'd3, '{0, 0, 32767, 32767, 32767, 0},           1'b0, '0},
            '{2'd3, '{0, 0, -32768, -32768, -32768, 0},        1'b0, '0},
            '{2'd3, '{-5, 7, 3, -3, 1, -1},                    1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (i != 0 && dir_rows[i].cfg_set != dir_rows[i - 1].cfg_set) begin
                drain_results();
                apply_cfg(dir_cfgs[dir_rows[i].cfg_set], 1'b0);
            end
            if (int'($urandom_range(0, 99)) < gap_pct) begin
                idle_cycles($urandom_range(1, 9));
            end
            send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].res);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            kind   = (p == 0 || p == RAND_PHASES - 1) ? 1 : int'($urandom_range(0, 4));
            garble = $urandom_range(0, 1);
            case (kind)
                0: begin
                    rc.lost_angle_limit = 15'($urandom);
                    rc.tilt_gain_p      = 24'($urandom);
                    rc.tilt_gain_d      = 24'($urandom);
                    rc.speed_gain_p     = 24'($urandom);
                    rc.speed_gain_i     = 24'($urandom);
                    rc.position_limit   = 23'($urandom);
                    rc.left_deadband    = 15'($urandom);
                    rc.right_deadband   = 15'($urandom);
                end
                2: rc = '1;
                3: rc = '0;
                default: begin
                    rc.lost_angle_limit = (kind == 4) ? 15'h7FFF : 15'($urandom_range(1000, 6000));
                    rc.tilt_gain_p      = 24'($urandom_range(0, 1 << 18));
                    rc.tilt_gain_d      = 24'($urandom_range(0, 1 << 16));
                    rc.speed_gain_p     = 24'($urandom_range(0, 1024));
                    rc.speed_gain_i     = 24'($urandom_range(0, 256));
                    if (kind == 4) begin
                        rc.position_limit = $urandom_range(0, 1) ? 23'h7FFFFF : 23'd0;
                    end else begin
                        rc.position_limit = 23'($urandom_range(0, 20000));
                    end
                    rc.left_deadband    = 15'($urandom_range(0, 3000));
                    rc.right_deadband   = 15'($urandom_range(0, 3000));
                end
            endcase
            apply_cfg(rc, garble);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
            if (p == RAND_PHASES - 1) begin
                quiet   = 1'b1;
                gap_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // tuned phases mostly see small, physical inputs
                tame = (kind == 1 || kind == 4) && ($urandom_range(0, 9) != 0);
                t.tilt_angle     = rnd_s16(tame ? 3500 : 32768);
                t.tilt_rate      = rnd_s16(tame ? 4000 : 32768);
                t.left_speed     = rnd_s16(tame ? 300 : 32768);
                t.right_speed    = rnd_s16(tame ? 300 : 32768);
                t.speed_setpoint = rnd_s16(tame ? 200 : 32768);
                t.turn_cmd       = rnd_s16(tame ? 3000 : 32768);
                if (int'($urandom_range(0, 99)) < gap_pct) begin
                    idle_cycles($urandom_range(1, 9));
                end
                send_tick(t, 1'b0, '0);
            end
        end

        drain_results();
        if (err_cnt == 0 && duty_q.size() == 0) begin
            $display("tb_balance_robot_cascade_controller_core: PASS");
        end else begin
            $display("tb_balance_robot_cascade_controller_core: FAIL");
        end
        $finish;
    end

endmodule
